FILE: sv/lca_pkg.sv
// ============================================================================
// Link capacity accounting package
// Shared types, codes and the saturating subtract used by the front queue,
// the accounting engine and the top level.
// ============================================================================
`default_nettype none

package lca_pkg;

    // Node ids are fixed at seven bits, so every node store has 128 entries.
    localparam int NODE_W     = 7;
    localparam int NODE_COUNT = 128;

    // Operation codes carried in the request.
    localparam logic [2:0] OP_ADD_LINK  = 3'd0;
    localparam logic [2:0] OP_ADD_IFR   = 3'd1;
    localparam logic [2:0] OP_ADD_TX    = 3'd2;
    localparam logic [2:0] OP_ADD_INT   = 3'd3;
    localparam logic [2:0] OP_HOP       = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    // Read targets.
    localparam logic [1:0] RK_LINK = 2'd0;
    localparam logic [1:0] RK_TX   = 2'd1;
    localparam logic [1:0] RK_INT  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNK_LINK  = 3'd1;
    localparam logic [2:0] ST_LINK_FULL = 3'd2;
    localparam logic [2:0] ST_IFR_FULL  = 3'd3;
    localparam logic [2:0] ST_UNK_NODE  = 3'd4;

    localparam logic signed [31:0] RES_MIN = 32'sh8000_0000;

    // One incoming request.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  src_node;
        logic [6:0]  dst_node;
        logic        wireless;
        logic [6:0]  node_id;
        logic [1:0]  read_kind;
        logic [23:0] traffic;
    } lca_in_t;

    // One result.
    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         link_slot;
        logic signed [31:0] residual;
    } lca_out_t;

    // Request class decided by the front part.
    typedef enum logic [3:0] {
        CL_ADD_LINK,
        CL_ADD_IFR,
        CL_ADD_TX,
        CL_ADD_INT,
        CL_HOP,
        CL_READ_LINK,
        CL_READ_TX,
        CL_READ_INT,
        CL_BAD_READ,
        CL_NOP
    } lca_class_t;

    // Classified request held in the queue.
    typedef struct packed {
        lca_class_t cls;
        lca_in_t    item;
    } lca_cmd_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic empty;
        logic full;
    } lca_q_stat_t;

    // Link key stored per table slot.
    typedef struct packed {
        logic [6:0] src;
        logic [6:0] dst;
        logic       wireless;
    } lca_key_t;

    // Engine sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_TX_RD,
        S_TX_WR,
        S_IFR_CHK,
        S_IFR_NODE,
        S_IFR_WR,
        S_LINK_USE,
        S_NODE_USE
    } lca_state_t;

    // Subtract traffic from a residual, saturating at the most negative value.
    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] r,
                                                   input logic [23:0] t);
        logic [32:0] d;
        d = {r[31], r} - {9'd0, t};
        if (d[32] != d[31])
            sub_sat = RES_MIN;
        else
            sub_sat = d[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/lca_front.sv
// ============================================================================
// Link capacity accounting front queue
// Accepts requests, classifies them and holds them in a two-entry queue
// until the engine takes them.
// ============================================================================
`default_nettype none

module lca_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire lca_pkg::lca_in_t   in_item,
    input  wire logic               pop,
    output logic                    q_valid,
    output lca_pkg::lca_cmd_t       q_cmd,
    output lca_pkg::lca_q_stat_t    q_stat
);

    lca_pkg::lca_cmd_t fifo_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic              do_pop;
    lca_pkg::lca_cmd_t new_cmd;

    // Decide what kind of work the request needs.
    always_comb
    begin
        new_cmd.item = in_item;
        case (in_item.opcode)
            lca_pkg::OP_ADD_LINK: new_cmd.cls = lca_pkg::CL_ADD_LINK;
            lca_pkg::OP_ADD_IFR:  new_cmd.cls = lca_pkg::CL_ADD_IFR;
            lca_pkg::OP_ADD_TX:   new_cmd.cls = lca_pkg::CL_ADD_TX;
            lca_pkg::OP_ADD_INT:  new_cmd.cls = lca_pkg::CL_ADD_INT;
            lca_pkg::OP_HOP:      new_cmd.cls = lca_pkg::CL_HOP;
            lca_pkg::OP_READ:
            begin
                case (in_item.read_kind)
                    lca_pkg::RK_LINK: new_cmd.cls = lca_pkg::CL_READ_LINK;
                    lca_pkg::RK_TX:   new_cmd.cls = lca_pkg::CL_READ_TX;
                    lca_pkg::RK_INT:  new_cmd.cls = lca_pkg::CL_READ_INT;
                    default:          new_cmd.cls = lca_pkg::CL_BAD_READ;
                endcase
            end
            default:              new_cmd.cls = lca_pkg::CL_NOP;
        endcase
    end

    assign in_stall     = (cnt_reg == 2'd2);
    assign push         = in_valid && !in_stall;
    assign q_valid      = (cnt_reg != 2'd0);
    assign do_pop       = pop && q_valid;
    assign q_cmd        = fifo_reg[rd_ptr_reg];
    assign q_stat.empty = (cnt_reg == 2'd0);
    assign q_stat.full  = (cnt_reg == 2'd2);

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= new_cmd;
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lca_engine.sv
// ============================================================================
// Link capacity accounting engine
// Carries out one classified request at a time against the link table,
// interferer lists and node stores, and holds the result until it is taken.
// ============================================================================
`default_nettype none

module lca_engine #(
    parameter int MAX_LINKS       = 256,
    parameter int MAX_INTERFERERS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [30:0]        cap,
    input  wire logic               q_valid,
    input  wire lca_pkg::lca_cmd_t  q_cmd,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output lca_pkg::lca_out_t       out_item
);

    localparam int LW   = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CW   = $clog2(MAX_LINKS + 1);
    localparam int LENW = $clog2(MAX_INTERFERERS + 1);
    localparam int IDS  = MAX_LINKS * MAX_INTERFERERS;
    localparam int IDW  = $clog2(IDS);
    localparam int NW   = lca_pkg::NODE_W;

    // Stores.
    lca_pkg::lca_key_t   key_mem [MAX_LINKS];
    logic [LENW-1:0]     len_mem [MAX_LINKS];
    logic signed [31:0]  res_mem [MAX_LINKS];
    logic [NW-1:0]       ids_mem [IDS];
    logic signed [31:0]  tx_mem  [lca_pkg::NODE_COUNT];
    logic signed [31:0]  int_mem [lca_pkg::NODE_COUNT];
    logic [lca_pkg::NODE_COUNT-1:0] tx_present_reg;
    logic [lca_pkg::NODE_COUNT-1:0] int_present_reg;

    // Registered read data.
    lca_pkg::lca_key_t   key_rd;
    logic [LENW-1:0]     len_rd;
    logic signed [31:0]  res_rd;
    logic [NW-1:0]       ids_rd;
    logic signed [31:0]  tx_rd;
    logic signed [31:0]  int_rd;

    // Store port controls.
    logic                key_we, key_re;
    logic [LW-1:0]       key_wa, key_ra;
    lca_pkg::lca_key_t   key_wd;
    logic [LENW-1:0]     len_wd;
    logic                res_we, res_re;
    logic [LW-1:0]       res_wa, res_ra;
    logic signed [31:0]  res_wd;
    logic                ids_we, ids_re;
    logic [IDW-1:0]      ids_wa, ids_ra;
    logic                tx_we, tx_re, tx_set;
    logic [NW-1:0]       tx_addr;
    logic signed [31:0]  tx_wd;
    logic                int_we, int_re, int_set;
    logic [NW-1:0]       int_addr;
    logic signed [31:0]  int_wd;

    // Sequencer registers.
    lca_pkg::lca_state_t state_reg, state_next;
    lca_pkg::lca_cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LW-1:0]       idx_reg, idx_next;
    logic [LENW-1:0]     len_reg, len_next;
    logic [LENW-1:0]     ifr_reg, ifr_next;
    logic [NW-1:0]       node_reg, node_next;
    logic                second_reg, second_next;
    logic                out_valid_reg;
    lca_pkg::lca_out_t   out_reg;
    logic                res_load;
    lca_pkg::lca_out_t   res_data;

    logic signed [31:0]  cap_s;
    logic signed [31:0]  hop_val;
    logic [IDW-1:0]      ids_base;

    assign cap_s     = {1'b0, cap};
    assign hop_val   = lca_pkg::sub_sat(res_rd, cmd_reg.item.traffic);
    assign ids_base  = IDW'(idx_reg) * IDW'(MAX_INTERFERERS);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Sequencer: next state, store accesses and result.
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        ifr_next    = ifr_reg;
        node_next   = node_reg;
        second_next = second_reg;
        pop      = 1'b0;
        key_we   = 1'b0;
        key_re   = 1'b0;
        key_wa   = idx_reg;
        key_ra   = idx_reg;
        key_wd   = '0;
        len_wd   = '0;
        res_we   = 1'b0;
        res_re   = 1'b0;
        res_wa   = idx_reg;
        res_ra   = idx_reg;
        res_wd   = hop_val;
        ids_we   = 1'b0;
        ids_re   = 1'b0;
        ids_wa   = ids_base + IDW'(len_rd);
        ids_ra   = ids_base + IDW'(ifr_reg);
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        tx_set   = 1'b0;
        tx_addr  = cmd_reg.item.src_node;
        tx_wd    = lca_pkg::sub_sat(tx_rd, cmd_reg.item.traffic);
        int_we   = 1'b0;
        int_re   = 1'b0;
        int_set  = 1'b0;
        int_addr = node_reg;
        int_wd   = lca_pkg::sub_sat(int_rd, cmd_reg.item.traffic);
        res_load = 1'b0;
        res_data = '0;

        case (state_reg)
            lca_pkg::S_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.cls)
                        lca_pkg::CL_ADD_LINK:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CW'(MAX_LINKS))
                                res_data.status = lca_pkg::ST_LINK_FULL;
                            else
                            begin
                                key_we = 1'b1;
                                key_wa = LW'(count_reg);
                                key_wd.src      = q_cmd.item.src_node;
                                key_wd.dst      = q_cmd.item.dst_node;
                                key_wd.wireless = q_cmd.item.wireless;
                                len_wd = '0;
                                res_we = 1'b1;
                                res_wa = LW'(count_reg);
                                res_wd = cap_s;
                                count_next = count_reg + CW'(1);
                                res_data.status    = lca_pkg::ST_OK;
                                res_data.link_slot = 8'(count_reg);
                                res_data.residual  = cap_s;
                            end
                        end
                        lca_pkg::CL_ADD_TX:
                        begin
                            tx_we    = 1'b1;
                            tx_set   = 1'b1;
                            tx_addr  = q_cmd.item.node_id;
                            tx_wd    = cap_s;
                            res_load = 1'b1;
                            res_data.residual = cap_s;
                        end
                        lca_pkg::CL_ADD_INT:
                        begin
                            int_we   = 1'b1;
                            int_set  = 1'b1;
                            int_addr = q_cmd.item.node_id;
                            int_wd   = cap_s;
                            res_load = 1'b1;
                            res_data.residual = cap_s;
                        end
                        lca_pkg::CL_READ_TX:
                        begin
                            if (tx_present_reg[q_cmd.item.node_id])
                            begin
                                tx_re      = 1'b1;
                                tx_addr    = q_cmd.item.node_id;
                                state_next = lca_pkg::S_NODE_USE;
                            end
                            else
                            begin
                                res_load        = 1'b1;
                                res_data.status = lca_pkg::ST_UNK_NODE;
                            end
                        end
                        lca_pkg::CL_READ_INT:
                        begin
                            if (int_present_reg[q_cmd.item.node_id])
                            begin
                                int_re     = 1'b1;
                                int_addr   = q_cmd.item.node_id;
                                state_next = lca_pkg::S_NODE_USE;
                            end
                            else
                            begin
                                res_load        = 1'b1;
                                res_data.status = lca_pkg::ST_UNK_NODE;
                            end
                        end
                        lca_pkg::CL_BAD_READ:
                        begin
                            res_load        = 1'b1;
                            res_data.status = lca_pkg::ST_UNK_NODE;
                        end
                        lca_pkg::CL_ADD_IFR, lca_pkg::CL_HOP, lca_pkg::CL_READ_LINK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load        = 1'b1;
                                res_data.status = lca_pkg::ST_UNK_LINK;
                            end
                            else
                            begin
                                idx_next   = LW'(count_reg - CW'(1));
                                state_next = lca_pkg::S_FIND_RD;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end

            // Read one table slot, newest first.
            lca_pkg::S_FIND_RD:
            begin
                key_re     = 1'b1;
                state_next = lca_pkg::S_FIND_CMP;
            end

            lca_pkg::S_FIND_CMP:
            begin
                if (key_rd.src == cmd_reg.item.src_node &&
                    key_rd.dst == cmd_reg.item.dst_node)
                begin
                    case (cmd_reg.cls)
                        lca_pkg::CL_ADD_IFR:
                        begin
                            if (len_rd >= LENW'(MAX_INTERFERERS))
                            begin
                                res_load        = 1'b1;
                                res_data.status = lca_pkg::ST_IFR_FULL;
                                state_next      = lca_pkg::S_IDLE;
                            end
                            else if (!int_present_reg[cmd_reg.item.node_id])
                            begin
                                res_load        = 1'b1;
                                res_data.status = lca_pkg::ST_UNK_NODE;
                                state_next      = lca_pkg::S_IDLE;
                            end
                            else
                            begin
                                ids_we     = 1'b1;
                                key_we     = 1'b1;
                                key_wd     = key_rd;
                                len_wd     = len_rd + LENW'(1);
                                res_re     = 1'b1;
                                state_next = lca_pkg::S_LINK_USE;
                            end
                        end
                        lca_pkg::CL_HOP:
                        begin
                            if (key_rd.wireless)
                            begin
                                if (!tx_present_reg[cmd_reg.item.src_node] ||
                                    !tx_present_reg[cmd_reg.item.dst_node])
                                begin
                                    res_load        = 1'b1;
                                    res_data.status = lca_pkg::ST_UNK_NODE;
                                    state_next      = lca_pkg::S_IDLE;
                                end
                                else
                                begin
                                    len_next    = len_rd;
                                    second_next = 1'b0;
                                    tx_re       = 1'b1;
                                    state_next  = lca_pkg::S_TX_WR;
                                end
                            end
                            else
                            begin
                                res_re     = 1'b1;
                                state_next = lca_pkg::S_LINK_USE;
                            end
                        end
                        default:
                        begin
                            res_re     = 1'b1;
                            state_next = lca_pkg::S_LINK_USE;
                        end
                    endcase
                end
                else if (idx_reg == '0)
                begin
                    res_load        = 1'b1;
                    res_data.status = lca_pkg::ST_UNK_LINK;
                    state_next      = lca_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - LW'(1);
                    state_next = lca_pkg::S_FIND_RD;
                end
            end

            // Charge the destination transceiver after the source one.
            lca_pkg::S_TX_RD:
            begin
                tx_re      = 1'b1;
                tx_addr    = cmd_reg.item.dst_node;
                state_next = lca_pkg::S_TX_WR;
            end

            lca_pkg::S_TX_WR:
            begin
                tx_we   = 1'b1;
                tx_addr = second_reg ? cmd_reg.item.dst_node : cmd_reg.item.src_node;
                if (!second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = lca_pkg::S_TX_RD;
                end
                else
                begin
                    ifr_next   = '0;
                    state_next = lca_pkg::S_IFR_CHK;
                end
            end

            // Walk the interferer list, one node per pass.
            lca_pkg::S_IFR_CHK:
            begin
                if (ifr_reg < len_reg)
                begin
                    ids_re     = 1'b1;
                    state_next = lca_pkg::S_IFR_NODE;
                end
                else
                begin
                    res_re     = 1'b1;
                    state_next = lca_pkg::S_LINK_USE;
                end
            end

            lca_pkg::S_IFR_NODE:
            begin
                int_re     = 1'b1;
                int_addr   = ids_rd;
                node_next  = ids_rd;
                state_next = lca_pkg::S_IFR_WR;
            end

            lca_pkg::S_IFR_WR:
            begin
                int_we     = 1'b1;
                ifr_next   = ifr_reg + LENW'(1);
                state_next = lca_pkg::S_IFR_CHK;
            end

            // Link residual is back: charge it on a hop, then report.
            lca_pkg::S_LINK_USE:
            begin
                res_load           = 1'b1;
                res_data.status    = lca_pkg::ST_OK;
                res_data.link_slot = 8'(idx_reg);
                if (cmd_reg.cls == lca_pkg::CL_HOP)
                begin
                    res_we            = 1'b1;
                    res_data.residual = hop_val;
                end
                else
                    res_data.residual = res_rd;
                state_next = lca_pkg::S_IDLE;
            end

            lca_pkg::S_NODE_USE:
            begin
                res_load          = 1'b1;
                res_data.residual = (cmd_reg.cls == lca_pkg::CL_READ_TX) ? tx_rd : int_rd;
                state_next        = lca_pkg::S_IDLE;
            end

            default:
            begin
                state_next = lca_pkg::S_IDLE;
            end
        endcase
    end

    // Link table stores.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
            len_mem[key_wa] <= len_wd;
        end
        if (key_re)
        begin
            key_rd <= key_mem[key_ra];
            len_rd <= len_mem[key_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_wa] <= res_wd;
        if (res_re)
            res_rd <= res_mem[res_ra];
    end

    // Interferer list store.
    always_ff @(posedge clk)
    begin
        if (ids_we)
            ids_mem[ids_wa] <= cmd_reg.item.node_id;
        if (ids_re)
            ids_rd <= ids_mem[ids_ra];
    end

    // Node residual stores.
    always_ff @(posedge clk)
    begin
        if (tx_we)
            tx_mem[tx_addr] <= tx_wd;
        if (tx_re)
            tx_rd <= tx_mem[tx_addr];
    end

    always_ff @(posedge clk)
    begin
        if (int_we)
            int_mem[int_addr] <= int_wd;
        if (int_re)
            int_rd <= int_mem[int_addr];
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (res_load)
            out_reg <= res_data;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lca_pkg::S_IDLE;
            count_reg       <= '0;
            tx_present_reg  <= '0;
            int_present_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (tx_set)
                tx_present_reg[tx_addr] <= 1'b1;
            if (int_set)
                int_present_reg[int_addr] <= 1'b1;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Per-request working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        ifr_reg    <= ifr_next;
        node_reg   <= node_next;
        second_reg <= second_next;
    end

endmodule

`default_nettype wire

FILE: sv/link_capacity_accounting_top.sv
// ============================================================================
// Link capacity accounting top level
// Residual capacity bookkeeping for links, transceivers and interference
// nodes, with a request queue in front of a single-request engine.
// ============================================================================
// Requests enter a two-entry queue and are carried out one at a time by an
// engine built around single-port memories. Registrations and unused opcodes
// reach the result register at the end of the cycle in which the engine takes
// them, and node reads in the cycle after that. Anything addressed by source
// and destination searches the link table newest slot first, reading and
// then comparing each slot that it scans. A hop on a wireless link then reads
// and writes back the two transceivers and each listed interference node in
// turn, and every link operation ends by reading or updating the residual.
// The engine takes a new request only once the previous result has left the
// output register, while the queue keeps taking requests until both of its
// entries are in use.
`default_nettype none

module link_capacity_accounting_top #(
    parameter int MAX_LINKS       = 256,
    parameter int MAX_INTERFERERS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [30:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire lca_pkg::lca_in_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output lca_pkg::lca_out_t      out_item
);

    logic [30:0]          cap_reg;
    logic                 q_valid;
    logic                 pop;
    lca_pkg::lca_cmd_t    q_cmd;
    lca_pkg::lca_q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    // Starting capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 31'd65536;
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    lca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_stat   (q_stat)
    );

    lca_engine #(
        .MAX_LINKS       (MAX_LINKS),
        .MAX_INTERFERERS (MAX_INTERFERERS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // An error result carries no slot and no residual.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != lca_pkg::ST_OK |->
            out_item.link_slot == 8'd0 && out_item.residual == 32'sd0)
        else $error("error result with nonzero fields");

    // The queue can never be empty and full together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue empty and full at once");

    // An empty queue never holds off a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !in_stall)
        else $error("stall with empty queue");

endmodule

`default_nettype wire
